// ===== rtl/ptw_pkg.sv =====
// ============================================================================
// ptw_pkg: shared types and constants of the page table walker
// Memory geometry, command and status codes, walk levels and the bundles
// that run between the walk controller and the datapath.
// ============================================================================
package ptw_pkg;

    // Table memory geometry: 2^MEM_ADDR_BITS words of 64 bits.
    localparam int MEM_ADDR_BITS = 16;
    localparam int WORD_IDX_W    = 49;   // frame (40 bits) and entry index (9 bits)

    // Override roots must lie strictly above this value.
    localparam logic [63:0] ROOT_LOWER_BOUND = 64'h0000_0000_0001_0000;

    // Configuration register reset values.
    localparam logic [63:0] DEFAULT_ROOT_RESET = 64'h0;
    localparam logic [63:0] ROOT_LIMIT_RESET   = 64'hFFFF_8000_0000_0000;

    // Page table entry bits.
    localparam int BIT_PRESENT   = 0;
    localparam int BIT_PAGE_SIZE = 7;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEFAULT_ROOT = 1'b0,
        CFG_ROOT_LIMIT   = 1'b1
    } cfg_index_t;

    // Input commands.
    typedef enum logic {
        CMD_WRITE     = 1'b0,
        CMD_TRANSLATE = 1'b1
    } command_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_ZERO_ADDR   = 3'd1,
        STAT_BAD_ROOT    = 3'd2,
        STAT_NOT_PRESENT = 3'd3,
        STAT_HUGE        = 3'd4,
        STAT_OUTSIDE     = 3'd5
    } status_t;

    // Walk levels.
    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    // Which fields a finished walk reports.
    typedef enum logic [1:0] {
        RES_EMPTY   = 2'd0,   // rejected before any read: level, address and value zero
        RES_OUTSIDE = 2'd1,   // address beyond the memory: level and address only
        RES_ENTRY   = 2'd2    // the entry last read
    } res_kind_t;

    // Controller state.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_START = 2'd1,
        S_EVAL  = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      mem_we;
        logic      sel_entry;
        logic      rd_en;
        logic      out_load;
        res_kind_t kind;
        status_t   status;
        logic      is_2m;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   va_zero;
        logic   root_bad;
        logic   outside;
        logic   present;
        logic   page_size;
        level_t level;
    } dp_stat_t;

endpackage

// ===== rtl/ptw_if.sv =====
// ============================================================================
// ptw_if: request and response channels of the page table walker
// Valid/ready channels; a transfer takes place at a rising edge at which
// valid and ready are both high.
// ============================================================================

// Request channel: table writes and translate requests.
interface ptw_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [47:0] vaddr;
    logic [63:0] root_override;
    logic [15:0] mem_word_addr;
    logic [63:0] mem_word_data;

    modport source (output valid, command, vaddr, root_override,
                    mem_word_addr, mem_word_data, input ready);
    modport sink   (input valid, command, vaddr, root_override,
                    mem_word_addr, mem_word_data, output ready);
endinterface

// Response channel: one result per translate request.
interface ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  fail_level;
    logic [51:0] entry_addr;
    logic [63:0] entry_value;
    logic        page_2m;

    modport source (output valid, status, fail_level, entry_addr, entry_value,
                    page_2m, input ready);
    modport sink   (input valid, status, fail_level, entry_addr, entry_value,
                    page_2m, output ready);
endinterface

// ===== rtl/ptw_ctrl.sv =====
// ============================================================================
// ptw_ctrl: walk controller
// State machine that sequences root checks and the level-by-level table
// reads, and owns the response valid flag.
// ============================================================================
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_command,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;
    logic      done;
    res_kind_t done_kind;
    status_t   done_status;
    logic      done_large;

    // The response register can take a new result when empty or draining.
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    // Walk decision for the current state.
    always_comb
    begin
        done        = 1'b0;
        done_kind   = RES_EMPTY;
        done_status = STAT_OK;
        done_large  = 1'b0;
        case (state_reg)
            S_START:
            begin
                if (stat.va_zero)
                begin
                    done        = 1'b1;
                    done_status = STAT_ZERO_ADDR;
                end
                else if (stat.root_bad)
                begin
                    done        = 1'b1;
                    done_status = STAT_BAD_ROOT;
                end
                else if (stat.outside)
                begin
                    done        = 1'b1;
                    done_kind   = RES_OUTSIDE;
                    done_status = STAT_OUTSIDE;
                end
            end
            S_EVAL:
            begin
                if (!stat.present)
                begin
                    done        = 1'b1;
                    done_kind   = RES_ENTRY;
                    done_status = STAT_NOT_PRESENT;
                end
                else if (stat.level == LVL_PDPT && stat.page_size)
                begin
                    done        = 1'b1;
                    done_kind   = RES_ENTRY;
                    done_status = STAT_HUGE;
                end
                else if (stat.level == LVL_PD && stat.page_size)
                begin
                    done        = 1'b1;
                    done_kind   = RES_ENTRY;
                    done_large  = 1'b1;
                end
                else if (stat.level == LVL_PT)
                begin
                    done        = 1'b1;
                    done_kind   = RES_ENTRY;
                end
                else if (stat.outside)
                begin
                    done        = 1'b1;
                    done_kind   = RES_OUTSIDE;
                    done_status = STAT_OUTSIDE;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_command == CMD_TRANSLATE)
                begin
                    state_next = S_START;
                end
            end
            S_START, S_EVAL:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs to the datapath and the request channel.
    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.kind      = done_kind;
        cmd.status    = done_status;
        cmd.is_2m     = done_large;
        case (state_reg)
            S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid && req_command == CMD_TRANSLATE;
                cmd.mem_we    = req_valid && req_command == CMD_WRITE;
            end
            S_START, S_EVAL:
            begin
                cmd.sel_entry = state_reg == S_EVAL;
                if (done)
                begin
                    cmd.out_load = out_free;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Response valid flag: set on a new result, cleared by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/ptw_datapath.sv =====
// ============================================================================
// ptw_datapath: page table walker datapath
// Table memory, configuration registers, walk address formation, entry
// checks and the response payload register.
// ============================================================================
module ptw_datapath
    import ptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    // Request payload
    input  logic [47:0]            vaddr,
    input  logic [63:0]            root_override,
    input  logic [15:0]            mem_word_addr,
    input  logic [63:0]            mem_word_data,
    // Controller link
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    // Response payload
    output logic [2:0]             status,
    output logic [1:0]             fail_level,
    output logic [51:0]            entry_addr,
    output logic [63:0]            entry_value,
    output logic                   page_2m
);

    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    logic [63:0]              mem [DEPTH];
    logic [63:0]              default_root_reg;
    logic [63:0]              root_limit_reg;
    logic [47:0]              va_reg;
    logic [63:0]              override_reg;
    level_t                   level_reg;
    logic [51:0]              addr_reg;
    logic [63:0]              rdata_reg;
    logic [2:0]               status_reg;
    level_t                   fail_level_reg;
    logic [51:0]              entry_addr_reg;
    logic [63:0]              entry_value_reg;
    logic                     large_reg;

    logic [63:0]              root_sel;
    logic [39:0]              cand_frame;
    level_t                   cand_level;
    logic [8:0]               cand_idx;
    logic [WORD_IDX_W-1:0]    cand_word;
    logic [51:0]              cand_addr;
    logic [MEM_ADDR_BITS+15:0] wr_addr_ext;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_root_reg <= DEFAULT_ROOT_RESET;
            root_limit_reg   <= ROOT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEFAULT_ROOT: default_root_reg <= cfg_data;
                CFG_ROOT_LIMIT:   root_limit_reg   <= cfg_data;
                default:          root_limit_reg   <= root_limit_reg;
            endcase
        end
    end

    // Root selection.
    assign root_sel = (override_reg == 64'h0) ? default_root_reg : override_reg;

    // Candidate entry address: frame of the previous level plus 8 * index.
    // The frame is page aligned, so the sum is a plain concatenation.
    assign cand_frame = cmd.sel_entry ? rdata_reg[51:12] : root_sel[51:12];
    assign cand_level = cmd.sel_entry ? level_t'(level_reg + 2'd1) : LVL_PML4;

    always_comb
    begin
        case (cand_level)
            LVL_PML4: cand_idx = va_reg[47:39];
            LVL_PDPT: cand_idx = va_reg[38:30];
            LVL_PD:   cand_idx = va_reg[29:21];
            LVL_PT:   cand_idx = va_reg[20:12];
            default:  cand_idx = va_reg[20:12];
        endcase
    end

    assign cand_word = {cand_frame, cand_idx};
    assign cand_addr = {cand_frame, cand_idx, 3'b000};

    // Root window check and entry checks on the word last read.
    always_comb
    begin
        stat.va_zero   = va_reg == 48'h0;
        stat.root_bad  = root_sel == 64'h0
                      || (override_reg != 64'h0
                          && !(override_reg > ROOT_LOWER_BOUND
                               && override_reg < root_limit_reg));
        stat.outside   = cand_word[WORD_IDX_W-1:MEM_ADDR_BITS] != '0;
        stat.present   = rdata_reg[BIT_PRESENT];
        stat.page_size = rdata_reg[BIT_PAGE_SIZE];
        stat.level     = level_reg;
    end

    // Item registers: the request when a translate is taken, the level and address on each read.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            va_reg       <= vaddr;
            override_reg <= root_override;
        end
        if (cmd.rd_en)
        begin
            level_reg <= cand_level;
            addr_reg  <= cand_addr;
        end
    end

    // Table memory: one write port for loads, one registered read port.
    assign wr_addr_ext = {{MEM_ADDR_BITS{1'b0}}, mem_word_addr};

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[wr_addr_ext[MEM_ADDR_BITS-1:0]] <= mem_word_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cand_word[MEM_ADDR_BITS-1:0]];
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.status;
            large_reg  <= cmd.is_2m;
            case (cmd.kind)
                RES_OUTSIDE:
                begin
                    fail_level_reg  <= cand_level;
                    entry_addr_reg  <= cand_addr;
                    entry_value_reg <= 64'h0;
                end
                RES_ENTRY:
                begin
                    fail_level_reg  <= level_reg;
                    entry_addr_reg  <= addr_reg;
                    entry_value_reg <= rdata_reg;
                end
                default:
                begin
                    fail_level_reg  <= LVL_PML4;
                    entry_addr_reg  <= 52'h0;
                    entry_value_reg <= 64'h0;
                end
            endcase
        end
    end

    assign status      = status_reg;
    assign fail_level  = fail_level_reg;
    assign entry_addr  = entry_addr_reg;
    assign entry_value = entry_value_reg;
    assign page_2m     = large_reg;

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// A translate rejected before any read has its result registered from the start
// state; otherwise the start state passes the root check and issues the first table
// read, and the evaluation state checks each entry read and reads the next level.
// The walker takes no new request until the result is loaded, which waits while the
// response register is full; writes are taken every cycle while the walker is idle.
// Reset: rst_n resets the controller and configuration; table memory stays undefined.
// ============================================================================
// four_level_page_table_walker: four-level page table walker top level
// Joins the walk controller and the datapath to the request, response and
// configuration ports.
// ============================================================================
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    ptw_req_if.sink                req,
    ptw_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Walk controller.
    ptw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Datapath with the table memory.
    ptw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .vaddr         (req.vaddr),
        .root_override (req.root_override),
        .mem_word_addr (req.mem_word_addr),
        .mem_word_data (req.mem_word_data),
        .cmd           (cmd),
        .stat          (stat),
        .status        (rsp.status),
        .fail_level    (rsp.fail_level),
        .entry_addr    (rsp.entry_addr),
        .entry_value   (rsp.entry_value),
        .page_2m       (rsp.page_2m)
    );

    // A translate transfer occupies the walker for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.command == CMD_TRANSLATE |=> !req.ready)
        else $error("walker took a request while a walk was in progress");

    // A 2 MB result is a successful directory level result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.page_2m
        |-> rsp.status == STAT_OK && rsp.fail_level == LVL_PD)
        else $error("large page reported outside a directory level success");

    // A 1 GB page is only ever found at the pointer directory level.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_HUGE |-> rsp.fail_level == LVL_PDPT)
        else $error("huge page reported at the wrong level");

    // Early rejections carry no entry information.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == STAT_ZERO_ADDR || rsp.status == STAT_BAD_ROOT)
        |-> rsp.entry_addr == 52'h0 && rsp.entry_value == 64'h0)
        else $error("rejected walk reported an entry");

endmodule
